### hdl/pts_pkg.sv
// Package with the shared types and constants of the power toggle sequencer.
`timescale 1ns / 1ps

package pts_pkg;

    // Request codes carried in the mode field.
    typedef enum logic [2:0] {
        MODE_TICK    = 3'd0,
        MODE_REQUEST = 3'd1,
        MODE_RX_EDGE = 3'd2,
        MODE_SUSPEND = 3'd3,
        MODE_RESUME  = 3'd4
    } mode_t;

    // Pin sequencing phase.
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_LOW    = 2'd1,
        PH_SETTLE = 2'd2
    } phase_t;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [1:0] REG_PULSE_LOW       = 2'd0;
    localparam logic [1:0] REG_SETTLE          = 2'd1;
    localparam logic [1:0] REG_INITIAL_BACKOFF = 2'd2;

    localparam int unsigned PADDR_BITS = 4;

    localparam logic [15:0] PULSE_LOW_RESET       = 16'd10;
    localparam logic [15:0] SETTLE_RESET          = 16'd10;
    localparam logic [15:0] INITIAL_BACKOFF_RESET = 16'd1000;

    typedef struct packed {
        logic [15:0] pulse_low_ticks;
        logic [15:0] settle_ticks;
        logic [15:0] initial_backoff_ticks;
    } cfg_t;

    typedef struct packed {
        logic       power_pin;
        logic       rx_monitor;
        logic       device_on;
        logic [1:0] phase;
        logic       busy_res;
    } result_t;

endpackage

### hdl/pts_in_if.sv
// Request channel interface of the power toggle sequencer.
`timescale 1ns / 1ps

interface pts_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic       level;

    modport source (output valid, output mode, output level, input ready);
    modport sink (input valid, input mode, input level, output ready);
endinterface

### hdl/pts_out_if.sv
// Result channel interface of the power toggle sequencer.
`timescale 1ns / 1ps

interface pts_out_if;
    logic       valid;
    logic       ready;
    logic       power_pin;
    logic       rx_monitor;
    logic       device_on;
    logic [1:0] phase;
    logic       busy_res;

    modport source (output valid, output power_pin, output rx_monitor, output device_on,
                    output phase, output busy_res, input ready);
    modport sink (input valid, input power_pin, input rx_monitor, input device_on,
                  input phase, input busy_res, output ready);
endinterface

### hdl/pts_core.sv
// Sequencer state and the single-pass update for one request.
`timescale 1ns / 1ps

module pts_core
    import pts_pkg::*;
#(
    parameter int unsigned TIMER_BITS = 20
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  logic [2:0] item_mode,
    input  logic       item_level,
    input  cfg_t       cfg,
    output result_t    res_next
);

    phase_t                phase_reg, phase_next;
    logic                  believed_on_reg, believed_on_next;
    logic                  wanted_on_reg, wanted_on_next;
    logic                  held_off_reg, held_off_next;
    logic                  monitoring_reg, monitoring_next;
    logic                  pin_level_reg, pin_level_next;
    logic                  step_pending_reg, step_pending_next;
    logic [15:0]           delay_count_reg, delay_count_next;
    logic [TIMER_BITS-1:0] since_toggle_reg, since_toggle_next;
    logic [TIMER_BITS-1:0] backoff_reg, backoff_next;

    always_comb
    begin
        logic target;
        logic run;

        phase_next        = phase_reg;
        believed_on_next  = believed_on_reg;
        wanted_on_next    = wanted_on_reg;
        held_off_next     = held_off_reg;
        monitoring_next   = monitoring_reg;
        pin_level_next    = pin_level_reg;
        step_pending_next = step_pending_reg;
        delay_count_next  = delay_count_reg;
        since_toggle_next = since_toggle_reg;
        backoff_next      = backoff_reg;
        run               = 1'b0;
        target            = 1'b0;

        case (item_mode)
            MODE_TICK:
            begin
                if (since_toggle_reg != '1)
                begin
                    since_toggle_next = since_toggle_reg + 1'b1;
                end
                if (step_pending_reg)
                begin
                    if (delay_count_reg != '0)
                    begin
                        delay_count_next = delay_count_reg - 1'b1;
                    end
                    run = (delay_count_next == '0);
                end
            end
            MODE_REQUEST:
            begin
                if (item_level && !wanted_on_reg)
                begin
                    monitoring_next = 1'b0;
                    wanted_on_next  = 1'b1;
                end
                else if (!item_level && wanted_on_reg)
                begin
                    backoff_next   = TIMER_BITS'(cfg.initial_backoff_ticks);
                    wanted_on_next = 1'b0;
                end
                // A request that changes the wanted level schedules a step now.
                if ((item_level != wanted_on_reg) && !held_off_reg && !step_pending_reg)
                begin
                    step_pending_next = 1'b1;
                    delay_count_next  = '0;
                end
            end
            MODE_RX_EDGE:
            begin
                if (monitoring_reg && !wanted_on_reg && !believed_on_reg &&
                    (phase_reg == PH_IDLE) && (since_toggle_reg > backoff_reg))
                begin
                    believed_on_next = 1'b1;
                    // Doubling saturates once the top bit is set.
                    backoff_next = backoff_reg[TIMER_BITS-1] ? '1 : (backoff_reg << 1);
                    if (!held_off_reg && !step_pending_reg)
                    begin
                        step_pending_next = 1'b1;
                        delay_count_next  = '0;
                    end
                end
            end
            MODE_SUSPEND:
            begin
                held_off_next = 1'b1;
                if (phase_reg == PH_IDLE)
                begin
                    step_pending_next = believed_on_reg;
                    delay_count_next  = '0;
                end
            end
            MODE_RESUME:
            begin
                held_off_next = 1'b0;
                if (!step_pending_reg)
                begin
                    step_pending_next = 1'b1;
                    delay_count_next  = '0;
                end
            end
            default:
            begin
            end
        endcase

        // Running a step always clears the pending flag first, so any step it
        // schedules replaces the old delay.
        if (run)
        begin
            step_pending_next = 1'b0;
            if (phase_reg == PH_LOW)
            begin
                pin_level_next    = 1'b1;
                phase_next        = PH_SETTLE;
                since_toggle_next = '0;
                believed_on_next  = !believed_on_reg;
                step_pending_next = 1'b1;
                delay_count_next  = cfg.settle_ticks;
            end
            else
            begin
                phase_next = PH_IDLE;
                target     = held_off_reg ? 1'b0 : wanted_on_reg;
                if (target == believed_on_reg)
                begin
                    if (!believed_on_reg && !held_off_reg)
                    begin
                        monitoring_next = 1'b1;
                    end
                end
                else
                begin
                    pin_level_next    = 1'b0;
                    phase_next        = PH_LOW;
                    step_pending_next = 1'b1;
                    delay_count_next  = cfg.pulse_low_ticks;
                end
            end
        end

        res_next.power_pin  = pin_level_next;
        res_next.rx_monitor = monitoring_next;
        res_next.device_on  = believed_on_next;
        res_next.phase      = phase_next;
        res_next.busy_res   = step_pending_next || (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            believed_on_reg  <= 1'b0;
            wanted_on_reg    <= 1'b1;
            held_off_reg     <= 1'b0;
            monitoring_reg   <= 1'b0;
            pin_level_reg    <= 1'b0;
            step_pending_reg <= 1'b0;
            delay_count_reg  <= '0;
            since_toggle_reg <= '0;
            backoff_reg      <= TIMER_BITS'(INITIAL_BACKOFF_RESET);
        end
        else if (step_en)
        begin
            phase_reg        <= phase_next;
            believed_on_reg  <= believed_on_next;
            wanted_on_reg    <= wanted_on_next;
            held_off_reg     <= held_off_next;
            monitoring_reg   <= monitoring_next;
            pin_level_reg    <= pin_level_next;
            step_pending_reg <= step_pending_next;
            delay_count_reg  <= delay_count_next;
            since_toggle_reg <= since_toggle_next;
            backoff_reg      <= backoff_next;
        end
    end

    // The pin is low while the low pulse runs and high while settling.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LOW) |-> !pin_level_reg)
    else $error("pin not low during the low pulse");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SETTLE) |-> pin_level_reg)
    else $error("pin not high while settling");

    // A running pulse or settle period always has its timed step pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> step_pending_reg)
    else $error("active phase without a pending step");

    // The receive line is only monitored while the device is wanted off.
    assert property (@(posedge clk) disable iff (!rst_n)
        monitoring_reg |-> !wanted_on_reg)
    else $error("monitoring while the device is wanted on");

endmodule

### hdl/power_toggle_sequencer_top.sv
// Top level of the power toggle sequencer: register port, request and result stages.
`timescale 1ns / 1ps

// The block keeps a device behind a toggle-only power pin in the requested
// on/off state. Requests arrive on in_ch (mode: tick, level request, receive
// edge, suspend, resume; level for a level request) and each one yields one
// result on out_ch: the pin level, the receive-monitor flag, the believed
// device state, the sequencing phase and a busy flag, all taken after that
// request has been applied. Pulse and settle lengths count tick requests.
// A request is registered when it is accepted; its result is computed from
// the request stage and registered once the result register is free or
// is being emptied. One request per cycle is sustained while the receiver
// takes results; the state update is a single pass of compares and
// counter steps between the request stage and the result register. When
// the receiver stalls, the result register holds and one further request
// is still taken into the request stage; in_ch ready drops only when both
// stages are full. Reset clears both stages and puts the device state,
// timers and registers at their reset values: the device is believed off,
// wanted on, and the backoff is 1000 ticks. The three timing registers are
// to be written over the APB port only while no request is in flight; the
// block does not enforce this. pready is always high.

module power_toggle_sequencer_top
    import pts_pkg::*;
#(
    parameter int unsigned TIMER_BITS = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    pts_in_if.sink                in_ch,
    pts_out_if.source             out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    cfg_t        cfg_reg;
    logic        cfg_write;
    logic [1:0]  reg_index;

    logic        req_valid_reg;
    logic [2:0]  req_mode_reg;
    logic        req_level_reg;
    logic        advance;
    logic        in_take;

    logic        out_valid_reg;
    result_t     out_res_reg;
    result_t     res_next;

    // ---------------- Configuration port ----------------
    assign pready    = 1'b1;
    assign reg_index = paddr[PADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulse_low_ticks       <= PULSE_LOW_RESET;
            cfg_reg.settle_ticks          <= SETTLE_RESET;
            cfg_reg.initial_backoff_ticks <= INITIAL_BACKOFF_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_PULSE_LOW:       cfg_reg.pulse_low_ticks       <= pwdata[15:0];
                REG_SETTLE:          cfg_reg.settle_ticks          <= pwdata[15:0];
                REG_INITIAL_BACKOFF: cfg_reg.initial_backoff_ticks <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_PULSE_LOW:       prdata = {16'd0, cfg_reg.pulse_low_ticks};
            REG_SETTLE:          prdata = {16'd0, cfg_reg.settle_ticks};
            REG_INITIAL_BACKOFF: prdata = {16'd0, cfg_reg.initial_backoff_ticks};
            default:             prdata = 32'd0;
        endcase
    end

    // ---------------- Request stage ----------------
    // The registered request moves on whenever the result register is free
    // or is being emptied in the same cycle.
    assign advance     = req_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !req_valid_reg || advance;
    assign in_take     = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= in_take || (req_valid_reg && !advance);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_mode_reg  <= in_ch.mode;
            req_level_reg <= in_ch.level;
        end
    end

    // ---------------- State update ----------------
    pts_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (advance),
        .item_mode  (req_mode_reg),
        .item_level (req_level_reg),
        .cfg        (cfg_reg),
        .res_next   (res_next)
    );

    // ---------------- Result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= advance || (out_valid_reg && !out_ch.ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= res_next;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.power_pin  = out_res_reg.power_pin;
    assign out_ch.rx_monitor = out_res_reg.rx_monitor;
    assign out_ch.device_on  = out_res_reg.device_on;
    assign out_ch.phase      = out_res_reg.phase;
    assign out_ch.busy_res   = out_res_reg.busy_res;

endmodule
